[rtl/core/price_time_order_matcher_core_macros.svh]
// Assertion macros shared by the checker of the order matcher core.
`ifndef PRICE_TIME_ORDER_MATCHER_CORE_MACROS_SVH
`define PRICE_TIME_ORDER_MATCHER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define PTOM_ASSERT_NOW(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("ptom check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define PTOM_ASSERT_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("ptom check failed");

`endif

[rtl/core/ptom_pkg.sv]
// Package of the order matcher core: sizes, codes, state type and control structs.
`default_nettype none
package ptom_pkg;

    localparam int BOOK_DEPTH = 32;
    localparam int IDX_W      = $clog2(BOOK_DEPTH);
    localparam int SUM_W      = 32 + IDX_W + 1;

    localparam logic [1:0] REQ_MARKET = 2'd0;
    localparam logic [1:0] REQ_LIMIT  = 2'd1;
    localparam logic [1:0] REQ_IOC    = 2'd2;
    localparam logic [1:0] REQ_FOK    = 2'd3;

    localparam logic [2:0] OC_FILLED    = 3'd0;
    localparam logic [2:0] OC_RESTED    = 3'd1;
    localparam logic [2:0] OC_CANCELLED = 3'd2;
    localparam logic [2:0] OC_KILLED    = 3'd3;
    localparam logic [2:0] OC_DROPPED   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_FOK_SUM,
        ST_FOK_CHECK,
        ST_SEARCH,
        ST_FILL,
        ST_FINISH,
        ST_FREE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       scan_clear;
        logic       fok_step;
        logic       search_step;
        logic       fill;
        logic       rest;
        logic       report;
        logic [2:0] outcome;
    } ptom_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic best_found;
        logic rem_zero;
        logic fill_closes;
        logic fok_short;
        logic kind_fok;
        logic kind_limit;
        logic slot_free;
    } ptom_stat_t;

endpackage
`default_nettype wire

[rtl/core/ptom_ctrl.sv]
// Controller state machine of the order matcher core.
`default_nettype none
module ptom_ctrl
    import ptom_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       start,
    input  wire ptom_stat_t stat,
    output ptom_cmd_t       cmd,
    output logic            busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (stat.kind_fok)
                begin
                    state_next = ST_FOK_SUM;
                end
                else if (stat.rem_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_FOK_SUM:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_FOK_CHECK;
                end
            end
            ST_FOK_CHECK:
            begin
                if (stat.fok_short)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.rem_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                if (!stat.best_found || stat.fill_closes)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_SEARCH;
                end
            end
            ST_FINISH:
            begin
                if (!stat.rem_zero && stat.kind_limit)
                begin
                    state_next = ST_FREE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FREE:
            begin
                if (stat.slot_free || stat.scan_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DISPATCH:
            begin
                cmd.scan_clear = 1'b1;
            end
            ST_FOK_SUM:
            begin
                cmd.fok_step = 1'b1;
            end
            ST_FOK_CHECK:
            begin
                cmd.scan_clear = 1'b1;
                cmd.report     = stat.fok_short;
                cmd.outcome    = OC_KILLED;
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
            end
            ST_FILL:
            begin
                cmd.fill       = stat.best_found;
                cmd.scan_clear = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.scan_clear = 1'b1;
                if (stat.rem_zero)
                begin
                    cmd.report  = 1'b1;
                    cmd.outcome = OC_FILLED;
                end
                else if (!stat.kind_limit)
                begin
                    cmd.report  = 1'b1;
                    cmd.outcome = OC_CANCELLED;
                end
            end
            ST_FREE:
            begin
                cmd.search_step = 1'b1;
                if (stat.slot_free)
                begin
                    cmd.rest    = 1'b1;
                    cmd.report  = 1'b1;
                    cmd.outcome = OC_RESTED;
                end
                else if (stat.scan_last)
                begin
                    cmd.report  = 1'b1;
                    cmd.outcome = OC_DROPPED;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/ptom_dp.sv]
// Datapath of the order matcher core: order book table, scan unit and result registers.
`default_nettype none
module ptom_dp
    import ptom_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire ptom_cmd_t   cmd,
    output ptom_stat_t       stat,
    input  wire logic [1:0]  req_type,
    input  wire logic        order_side,
    input  wire logic [31:0] limit_price,
    input  wire logic [31:0] order_quantity,
    input  wire logic [31:0] order_ident,
    output logic             result_strobe,
    output logic             item_kind,
    output logic [31:0]      trade_number,
    output logic [31:0]      maker_ident,
    output logic [31:0]      taker_ident,
    output logic [31:0]      trade_price,
    output logic [31:0]      fill_quantity,
    output logic             aggressor_side,
    output logic [31:0]      left_quantity,
    output logic [2:0]       outcome,
    output logic             last_item
);

    logic [BOOK_DEPTH-1:0] valid_reg;
    logic                  side_mem_reg  [BOOK_DEPTH];
    logic [31:0]           price_mem_reg [BOOK_DEPTH];
    logic [31:0]           qty_mem_reg   [BOOK_DEPTH];
    logic [31:0]           ident_mem_reg [BOOK_DEPTH];
    logic [31:0]           arr_mem_reg   [BOOK_DEPTH];

    logic [31:0]      arrival_reg;
    logic [31:0]      trades_reg;
    logic [IDX_W-1:0] idx_reg;

    logic [1:0]       kind_reg;
    logic             side_reg;
    logic [31:0]      lim_reg;
    logic [31:0]      qty_reg;
    logic [31:0]      ident_reg;
    logic [31:0]      rem_reg;
    logic [SUM_W-1:0] sum_reg;

    logic             found_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [31:0]      best_price_reg;
    logic [31:0]      best_qty_reg;
    logic [31:0]      best_ident_reg;
    logic [31:0]      best_age_reg;

    logic        rd_valid;
    logic        rd_side;
    logic [31:0] rd_price;
    logic [31:0] rd_qty;
    logic [31:0] rd_age;
    logic        price_ok;
    logic        eligible;
    logic        better;
    logic [31:0] fill_q;

    assign rd_valid = valid_reg[idx_reg];
    assign rd_side  = side_mem_reg[idx_reg];
    assign rd_price = price_mem_reg[idx_reg];
    assign rd_qty   = qty_mem_reg[idx_reg];
    assign rd_age   = arrival_reg - arr_mem_reg[idx_reg];

    always_comb
    begin
        if (kind_reg == REQ_MARKET)
        begin
            price_ok = 1'b1;
        end
        else if (side_reg == 1'b0)
        begin
            price_ok = lim_reg >= rd_price;
        end
        else
        begin
            price_ok = lim_reg <= rd_price;
        end
    end

    assign eligible = rd_valid && (rd_side != side_reg) && price_ok;

    always_comb
    begin
        if (!found_reg)
        begin
            better = 1'b1;
        end
        else if (rd_price == best_price_reg)
        begin
            better = rd_age > best_age_reg;
        end
        else if (side_reg == 1'b0)
        begin
            better = rd_price < best_price_reg;
        end
        else
        begin
            better = rd_price > best_price_reg;
        end
    end

    assign fill_q = (rem_reg < best_qty_reg) ? rem_reg : best_qty_reg;

    always_comb
    begin
        stat.scan_last   = idx_reg == IDX_W'(BOOK_DEPTH - 1);
        stat.best_found  = found_reg;
        stat.rem_zero    = rem_reg == 32'd0;
        stat.fill_closes = rem_reg <= best_qty_reg;
        stat.fok_short   = sum_reg < SUM_W'(qty_reg);
        stat.kind_fok    = kind_reg == REQ_FOK;
        stat.kind_limit  = kind_reg == REQ_LIMIT;
        stat.slot_free   = !rd_valid;
    end

    // Control state with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            arrival_reg   <= '0;
            trades_reg    <= '0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
            result_strobe <= 1'b0;
        end
        else
        begin
            result_strobe <= cmd.fill || cmd.report;
            if (cmd.scan_clear || cmd.load)
            begin
                idx_reg   <= '0;
                found_reg <= 1'b0;
            end
            else if (cmd.fok_step || cmd.search_step)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (cmd.search_step && eligible && better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.fill)
            begin
                trades_reg <= trades_reg + 32'd1;
                if (rem_reg >= best_qty_reg)
                begin
                    valid_reg[best_idx_reg] <= 1'b0;
                end
            end
            if (cmd.rest)
            begin
                valid_reg[idx_reg] <= 1'b1;
                arrival_reg        <= arrival_reg + 32'd1;
            end
        end
    end

    // Payload registers and book table contents.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= req_type;
            side_reg  <= order_side;
            lim_reg   <= limit_price;
            qty_reg   <= order_quantity;
            ident_reg <= order_ident;
            rem_reg   <= order_quantity;
            sum_reg   <= '0;
        end
        if (cmd.fok_step && eligible)
        begin
            sum_reg <= sum_reg + SUM_W'(rd_qty);
        end
        if (cmd.search_step && eligible && better)
        begin
            best_idx_reg   <= idx_reg;
            best_price_reg <= rd_price;
            best_qty_reg   <= rd_qty;
            best_ident_reg <= ident_mem_reg[idx_reg];
            best_age_reg   <= rd_age;
        end
        if (cmd.fill)
        begin
            rem_reg                    <= rem_reg - fill_q;
            qty_mem_reg[best_idx_reg]  <= best_qty_reg - fill_q;
        end
        if (cmd.rest)
        begin
            side_mem_reg[idx_reg]  <= side_reg;
            price_mem_reg[idx_reg] <= lim_reg;
            qty_mem_reg[idx_reg]   <= rem_reg;
            ident_mem_reg[idx_reg] <= ident_reg;
            arr_mem_reg[idx_reg]   <= arrival_reg;
        end
        if (cmd.fill)
        begin
            item_kind      <= 1'b0;
            trade_number   <= trades_reg + 32'd1;
            maker_ident    <= best_ident_reg;
            taker_ident    <= ident_reg;
            trade_price    <= best_price_reg;
            fill_quantity  <= fill_q;
            aggressor_side <= side_reg;
            left_quantity  <= 32'd0;
            outcome        <= OC_FILLED;
            last_item      <= 1'b0;
        end
        else if (cmd.report)
        begin
            item_kind      <= 1'b1;
            trade_number   <= 32'd0;
            maker_ident    <= 32'd0;
            taker_ident    <= ident_reg;
            trade_price    <= 32'd0;
            fill_quantity  <= 32'd0;
            aggressor_side <= side_reg;
            left_quantity  <= (cmd.outcome == OC_KILLED) ? qty_reg : rem_reg;
            outcome        <= cmd.outcome;
            last_item      <= 1'b1;
        end
    end

endmodule
`default_nettype wire

[rtl/core/price_time_order_matcher_core.sv]
// Top level of the price-time priority order matcher core.
// An order is transferred in when start is high while busy is low. The core
// then runs with busy high. Each search pass reads one table slot per cycle
// over the 32-entry book and is followed by a fill state that records the
// trade it found, if any. The number of passes is the number of fills, plus
// one more when the order is not fully filled, for the last pass that finds
// nothing to match. A fill-or-kill order first sums the liquidity it could
// match over the book, and a killed one is reported after that sum with no
// search pass. A limit remainder is rested in the lowest free slot, found by
// a scan of the book, or dropped when no slot is free. Every result, trades
// first and then the final report with last_item high, is shown for exactly one
// cycle with result_strobe high. The receiver cannot stall, so it must take each
// transfer as it comes. The final report is shown in the first cycle with busy
// low, so the next order can be transferred in during that same cycle.
`default_nettype none
module price_time_order_matcher_core
    import ptom_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  req_type,
    input  wire logic        order_side,
    input  wire logic [31:0] limit_price,
    input  wire logic [31:0] order_quantity,
    input  wire logic [31:0] order_ident,
    output logic             result_strobe,
    output logic             item_kind,
    output logic [31:0]      trade_number,
    output logic [31:0]      maker_ident,
    output logic [31:0]      taker_ident,
    output logic [31:0]      trade_price,
    output logic [31:0]      fill_quantity,
    output logic             aggressor_side,
    output logic [31:0]      left_quantity,
    output logic [2:0]       outcome,
    output logic             last_item
);

    // Commands from the controller and status back from the datapath.
    ptom_cmd_t  cmd;
    ptom_stat_t stat;

    ptom_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ptom_dp u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .req_type       (req_type),
        .order_side     (order_side),
        .limit_price    (limit_price),
        .order_quantity (order_quantity),
        .order_ident    (order_ident),
        .result_strobe  (result_strobe),
        .item_kind      (item_kind),
        .trade_number   (trade_number),
        .maker_ident    (maker_ident),
        .taker_ident    (taker_ident),
        .trade_price    (trade_price),
        .fill_quantity  (fill_quantity),
        .aggressor_side (aggressor_side),
        .left_quantity  (left_quantity),
        .outcome        (outcome),
        .last_item      (last_item)
    );

endmodule
`default_nettype wire

[rtl/core/ptom_checker.sv]
// Port-level checker of the order matcher core and its bind.
`default_nettype none
`include "price_time_order_matcher_core_macros.svh"
module ptom_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        result_strobe,
    input wire logic        item_kind,
    input wire logic [31:0] fill_quantity,
    input wire logic [2:0]  outcome,
    input wire logic        last_item
);

    // A transfer in always starts work.
    `PTOM_ASSERT_NEXT(a_start_busy, start && !busy, busy)
    // Only the final report closes an order, and it carries a defined outcome.
    `PTOM_ASSERT_NOW(a_last_is_report, result_strobe, last_item == item_kind)
    `PTOM_ASSERT_NOW(a_outcome_range, result_strobe && item_kind, outcome <= 3'd4)
    // A trade never has an empty fill.
    `PTOM_ASSERT_NOW(a_trade_nonzero, result_strobe && !item_kind, fill_quantity != 32'd0)
    // Trades are only produced while the core is working on an order.
    `PTOM_ASSERT_NOW(a_trade_busy, result_strobe && !item_kind, busy)

endmodule

bind price_time_order_matcher_core ptom_checker u_ptom_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_strobe (result_strobe),
    .item_kind     (item_kind),
    .fill_quantity (fill_quantity),
    .outcome       (outcome),
    .last_item     (last_item)
);
`default_nettype wire
